>>> sv/tsp_pkg.sv
package tsp_pkg;

   localparam logic [2:0] REC_TYPE = 3'd0;
   localparam logic [2:0] REC_VMAJ = 3'd1;
   localparam logic [2:0] REC_VMIN = 3'd2;
   localparam logic [2:0] REC_LEN0 = 3'd3;
   localparam logic [2:0] REC_LEN1 = 3'd4;
   localparam logic [2:0] REC_BODY = 3'd5;
   localparam logic [2:0] REC_DEAD = 3'd6;

   localparam logic [2:0] IN_TYPE = 3'd0;
   localparam logic [2:0] IN_LEN0 = 3'd1;
   localparam logic [2:0] IN_LEN1 = 3'd2;
   localparam logic [2:0] IN_LEN2 = 3'd3;
   localparam logic [2:0] IN_BODY = 3'd4;
   localparam logic [2:0] IN_DEAD = 3'd5;

   localparam logic [4:0] H_VMAJ    = 5'd0;
   localparam logic [4:0] H_VMIN    = 5'd1;
   localparam logic [4:0] H_TIME0   = 5'd2;
   localparam logic [4:0] H_TIME1   = 5'd3;
   localparam logic [4:0] H_TIME2   = 5'd4;
   localparam logic [4:0] H_TIME3   = 5'd5;
   localparam logic [4:0] H_RANDOM  = 5'd6;
   localparam logic [4:0] H_SESSLEN = 5'd7;
   localparam logic [4:0] H_SESSID  = 5'd8;
   localparam logic [4:0] H_CIPH0   = 5'd9;
   localparam logic [4:0] H_CIPH1   = 5'd10;
   localparam logic [4:0] H_COMP    = 5'd11;
   localparam logic [4:0] H_LEN0    = 5'd12;
   localparam logic [4:0] H_LEN1    = 5'd13;
   localparam logic [4:0] H_TAG0    = 5'd14;
   localparam logic [4:0] H_TAG1    = 5'd15;
   localparam logic [4:0] H_ELEN0   = 5'd16;
   localparam logic [4:0] H_ELEN1   = 5'd17;
   localparam logic [4:0] H_DATA    = 5'd18;
   localparam logic [4:0] H_HBDATA  = 5'd19;
   localparam logic [4:0] H_DEAD    = 5'd20;

   localparam logic [2:0] C_LEN0  = 3'd0;
   localparam logic [2:0] C_LEN1  = 3'd1;
   localparam logic [2:0] C_LEN2  = 3'd2;
   localparam logic [2:0] C_CLEN0 = 3'd3;
   localparam logic [2:0] C_CLEN1 = 3'd4;
   localparam logic [2:0] C_CLEN2 = 3'd5;
   localparam logic [2:0] C_CERT  = 3'd6;
   localparam logic [2:0] C_DEAD  = 3'd7;

   localparam logic [7:0]  KIND_HANDSHAKE = 8'd22;
   localparam logic [7:0]  KIND_HEARTBEAT = 8'd24;
   localparam logic [7:0]  MSG_HELLO      = 8'd2;
   localparam logic [7:0]  MSG_CERT       = 8'd11;
   localparam logic [7:0]  HB_RESPONSE    = 8'd2;
   localparam logic [15:0] EXT_HEARTBEAT  = 16'h000f;
   localparam logic [15:0] RANDOM_LEN     = 16'd28;
   localparam logic [23:0] BLEED_MIN      = 24'd16;

   localparam logic [1:0] CSR_CAPTURE_CERT  = 2'd0;
   localparam logic [1:0] CSR_CAPTURE_BLEED = 2'd1;
   localparam logic [1:0] CSR_BLEED_MODE    = 2'd2;

   typedef struct packed {
      logic capture_cert;
      logic capture_heartbleed;
      logic heartbleed_mode;
   } tsp_cfg_type;

   typedef struct packed {
      logic [2:0]  record_phase;
      logic [15:0] record_left;
      logic [7:0]  record_kind;
      logic [2:0]  inner_phase;
      logic [23:0] inner_left;
      logic [7:0]  message_kind;
      logic [4:0]  hello_phase;
      logic [15:0] hello_left;
      logic [7:0]  hello_major;
      logic [15:0] suite_acc;
      logic [15:0] ext_kind;
      logic [15:0] ext_left;
      logic [2:0]  chain_phase;
      logic [23:0] chain_left;
      logic [23:0] cert_left;
   } tsp_state_type;

   typedef struct packed {
      logic        cipher_valid;
      logic [15:0] suite_id;
      logic        heartbeat_ext_seen;
      logic        heartbleed_seen;
      logic        send_probe;
      logic        capture_start;
      logic        payload_valid;
      logic        payload_kind;
      logic        capture_end;
      logic        scan_done;
      logic        stream_dead;
   } tsp_result_type;

endpackage

>>> sv/tsp_req_if.sv
interface tsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       new_connection;

   modport source (output valid, output rx_byte, output new_connection, input ready);
   modport sink (input valid, input rx_byte, input new_connection, output ready);
endinterface

>>> sv/tsp_rsp_if.sv
interface tsp_rsp_if;
   logic        valid;
   logic        ready;
   logic        cipher_valid;
   logic [15:0] suite_id;
   logic        heartbeat_ext_seen;
   logic        heartbleed_seen;
   logic        send_probe;
   logic        capture_start;
   logic        payload_valid;
   logic        payload_kind;
   logic        capture_end;
   logic        scan_done;
   logic        stream_dead;

   modport source (output valid, output cipher_valid, output suite_id,
      output heartbeat_ext_seen, output heartbleed_seen, output send_probe,
      output capture_start, output payload_valid, output payload_kind,
      output capture_end, output scan_done, output stream_dead, input ready);
   modport sink (input valid, input cipher_valid, input suite_id,
      input heartbeat_ext_seen, input heartbleed_seen, input send_probe,
      input capture_start, input payload_valid, input payload_kind,
      input capture_end, input scan_done, input stream_dead, output ready);
endinterface

>>> sv/tsp_core.sv
module tsp_core
   import tsp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           step,
   input  logic [7:0]     rx_byte,
   input  logic           new_connection,
   input  tsp_cfg_type    cfg,
   output tsp_result_type result
);

   localparam tsp_state_type CLEAR = '{
      record_phase: REC_TYPE, inner_phase: IN_TYPE, hello_phase: H_VMAJ,
      chain_phase: C_LEN0, default: '0};

   tsp_state_type state_ff, state_in;

   always_comb begin
      tsp_state_type s;
      tsp_result_type o;
      logic [7:0] b;
      logic [2:0] rp;
      logic [2:0] ip;
      logic [4:0] hp;
      logic [2:0] cp;
      logic do_hs;
      logic do_hb;
      logic do_hello;
      logic do_chain;

      b = rx_byte;
      s = new_connection ? CLEAR : state_ff;
      o = '0;
      ip = IN_TYPE;
      hp = H_VMAJ;
      cp = C_LEN0;
      do_hs = 1'b0;
      do_hb = 1'b0;
      do_hello = 1'b0;
      do_chain = 1'b0;

      // record layer
      rp = s.record_phase;
      if (rp == REC_BODY && s.record_left == '0) begin
         rp = REC_TYPE;
      end
      case (rp)
         REC_TYPE: begin
            if (b[7]) begin
               s.record_phase = REC_DEAD;
            end else begin
               if (s.record_kind != b) begin
                  s.record_kind = b;
                  s.inner_phase = IN_TYPE;
               end
               s.record_phase = REC_VMAJ;
            end
         end
         REC_VMAJ: s.record_phase = (b != 8'd3) ? REC_DEAD : REC_VMIN;
         REC_VMIN: s.record_phase = REC_LEN0;
         REC_LEN0: begin
            s.record_left = {b, 8'd0};
            s.record_phase = REC_LEN1;
         end
         REC_LEN1: begin
            s.record_left = {s.record_left[15:8], b};
            s.record_phase = REC_BODY;
         end
         REC_BODY: begin
            do_hs = (s.record_kind == KIND_HANDSHAKE);
            do_hb = (s.record_kind == KIND_HEARTBEAT);
            s.record_left = s.record_left - 16'd1;
            if (s.record_left == '0) begin
               s.record_phase = REC_TYPE;
            end
         end
         default: ;
      endcase

      // handshake layer
      if (do_hs) begin
         ip = s.inner_phase;
         if (ip == IN_BODY && s.inner_left == '0) begin
            ip = IN_TYPE;
         end
         case (ip)
            IN_TYPE: begin
               if (b[7]) begin
                  s.inner_phase = IN_DEAD;
               end else begin
                  s.message_kind = b;
                  s.hello_phase = H_VMAJ;
                  s.chain_phase = C_LEN0;
                  s.inner_phase = IN_LEN0;
               end
            end
            IN_LEN0: begin
               s.inner_left = {16'd0, b};
               s.inner_phase = IN_LEN1;
            end
            IN_LEN1: begin
               s.inner_left = {s.inner_left[15:0], b};
               s.inner_phase = IN_LEN2;
            end
            IN_LEN2: begin
               s.inner_left = {s.inner_left[15:0], b};
               o.send_probe = (s.message_kind == MSG_HELLO);
               s.inner_phase = IN_BODY;
            end
            IN_BODY: begin
               do_hello = (s.message_kind == MSG_HELLO);
               do_chain = (s.message_kind == MSG_CERT);
               s.inner_left = s.inner_left - 24'd1;
               if (s.inner_left == '0) begin
                  s.inner_phase = IN_TYPE;
               end
            end
            default: ;
         endcase
      end

      // heartbeat layer
      if (do_hb) begin
         case (s.inner_phase)
            IN_TYPE: begin
               if (b < 8'd1 || b > 8'd2) begin
                  s.inner_phase = IN_DEAD;
               end else begin
                  s.message_kind = b;
                  s.inner_phase = IN_LEN0;
               end
            end
            IN_LEN0: begin
               s.inner_left = {16'd0, b};
               s.inner_phase = IN_LEN1;
            end
            IN_LEN1: begin
               s.inner_left = {s.inner_left[15:0], b};
               if (s.message_kind == HB_RESPONSE) begin
                  o.heartbleed_seen = (s.inner_left >= BLEED_MIN);
                  if (cfg.capture_heartbleed) begin
                     o.capture_start = 1'b1;
                     o.payload_kind = 1'b1;
                  end
               end
               s.inner_phase = IN_BODY;
            end
            IN_BODY: begin
               if (s.inner_left == '0) begin
                  s.inner_phase = IN_DEAD;
               end else begin
                  if (s.message_kind == HB_RESPONSE && cfg.capture_heartbleed) begin
                     o.payload_valid = 1'b1;
                     o.payload_kind = 1'b1;
                  end
                  s.inner_left = s.inner_left - 24'd1;
                  if (s.inner_left == '0) begin
                     s.inner_phase = IN_DEAD;
                  end
               end
            end
            default: ;
         endcase
      end

      // server hello
      if (do_hello) begin
         hp = s.hello_phase;
         if (hp == H_RANDOM && s.hello_left == '0) begin
            hp = H_SESSLEN;
         end else if (hp == H_SESSID && s.hello_left == '0) begin
            s.suite_acc = '0;
            hp = H_CIPH0;
         end else if ((hp == H_DATA || hp == H_HBDATA) && s.ext_left == '0) begin
            hp = H_TAG0;
         end
         case (hp)
            H_VMAJ: begin
               s.hello_major = b;
               s.hello_phase = H_VMIN;
            end
            H_VMIN: begin
               s.hello_phase = (s.hello_major > 8'd3 || b > 8'd4) ? H_DEAD : H_TIME0;
            end
            H_TIME0, H_TIME1, H_TIME2: s.hello_phase = hp + 5'd1;
            H_TIME3: begin
               s.hello_left = RANDOM_LEN;
               s.hello_phase = H_RANDOM;
            end
            H_RANDOM: begin
               s.hello_phase = hp;
               s.hello_left = s.hello_left - 16'd1;
               if (s.hello_left == '0) begin
                  s.hello_phase = H_SESSLEN;
               end
            end
            H_SESSLEN: begin
               s.hello_left = {8'd0, b};
               s.hello_phase = H_SESSID;
            end
            H_SESSID: begin
               s.hello_phase = hp;
               s.hello_left = s.hello_left - 16'd1;
               if (s.hello_left == '0) begin
                  s.suite_acc = '0;
                  s.hello_phase = H_CIPH0;
               end
            end
            H_CIPH0: begin
               s.suite_acc = {s.suite_acc[7:0], b};
               s.hello_phase = H_CIPH1;
            end
            H_CIPH1: begin
               s.suite_acc = {s.suite_acc[7:0], b};
               o.cipher_valid = 1'b1;
               o.suite_id = s.suite_acc;
               s.hello_phase = H_COMP;
            end
            H_COMP: s.hello_phase = H_LEN0;
            H_LEN0: begin
               s.hello_left = {8'd0, b};
               s.hello_phase = H_LEN1;
            end
            H_LEN1: begin
               s.hello_left = {s.hello_left[7:0], b};
               s.hello_phase = H_TAG0;
            end
            H_TAG0: begin
               if (s.hello_left < 16'd4) begin
                  s.hello_phase = H_DEAD;
               end else begin
                  s.ext_kind = {b, 8'd0};
                  s.hello_left = s.hello_left - 16'd1;
                  s.hello_phase = H_TAG1;
               end
            end
            H_TAG1: begin
               s.ext_kind = {s.ext_kind[15:8], b};
               s.hello_left = s.hello_left - 16'd1;
               s.hello_phase = H_ELEN0;
            end
            H_ELEN0: begin
               s.ext_left = {b, 8'd0};
               s.hello_left = s.hello_left - 16'd1;
               s.hello_phase = H_ELEN1;
            end
            H_ELEN1: begin
               s.ext_left = {s.ext_left[15:8], b};
               s.hello_left = s.hello_left - 16'd1;
               s.hello_phase = (s.ext_kind == EXT_HEARTBEAT) ? H_HBDATA : H_DATA;
            end
            H_DATA, H_HBDATA: begin
               if (s.hello_left == '0) begin
                  s.hello_phase = H_DEAD;
               end else begin
                  s.hello_left = s.hello_left - 16'd1;
                  s.ext_left = s.ext_left - 16'd1;
                  o.heartbeat_ext_seen = (hp == H_HBDATA) && (b != 8'd0);
                  s.hello_phase = H_DATA;
               end
            end
            default: ;
         endcase
      end

      // certificate chain
      if (do_chain) begin
         cp = s.chain_phase;
         if (cp == C_CERT && s.cert_left == '0) begin
            o.capture_end = cfg.capture_cert;
            o.scan_done = (s.chain_left == '0) && !cfg.heartbleed_mode;
            cp = C_CLEN0;
         end
         case (cp)
            C_LEN0: begin
               s.chain_left = {16'd0, b};
               s.chain_phase = C_LEN1;
            end
            C_LEN1, C_LEN2: begin
               s.chain_left = {s.chain_left[15:0], b};
               s.chain_phase = cp + 3'd1;
            end
            C_CLEN0: begin
               if (s.chain_left < 24'd3) begin
                  s.chain_phase = C_DEAD;
               end else begin
                  s.cert_left = {16'd0, b};
                  s.chain_left = s.chain_left - 24'd1;
                  s.chain_phase = C_CLEN1;
               end
            end
            C_CLEN1: begin
               s.cert_left = {s.cert_left[15:0], b};
               s.chain_left = s.chain_left - 24'd1;
               s.chain_phase = C_CLEN2;
            end
            C_CLEN2: begin
               s.cert_left = {s.cert_left[15:0], b};
               s.chain_left = s.chain_left - 24'd1;
               o.capture_start = cfg.capture_cert;
               s.chain_phase = C_CERT;
            end
            C_CERT: begin
               if (s.chain_left == '0) begin
                  s.chain_phase = C_DEAD;
               end else begin
                  if (cfg.capture_cert) begin
                     o.payload_valid = 1'b1;
                     o.payload_kind = 1'b0;
                  end
                  s.chain_left = s.chain_left - 24'd1;
                  s.cert_left = s.cert_left - 24'd1;
                  if (s.cert_left == '0) begin
                     o.capture_end = o.capture_end | cfg.capture_cert;
                     s.chain_phase = C_CLEN0;
                     o.scan_done = o.scan_done |
                        ((s.chain_left == '0) && !cfg.heartbleed_mode);
                  end
               end
            end
            default: ;
         endcase
      end

      o.stream_dead = (s.record_phase >= REC_DEAD);
      state_in = s;
      result = o;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CLEAR;
      end else if (step) begin
         state_ff <= state_in;
      end
   end

endmodule

>>> sv/tls_server_stream_parser_unit.sv
// channel | dir | beat payload
// req     | in  | rx_byte, new_connection
// rsp     | out | cipher_valid .. stream_dead, one beat per req beat
// csr     | in  | csr_we, csr_index (2b), csr_wdata (1b)
// one beat per cycle; a result appears the cycle after its byte is taken
// the parser state update and result are one combinational pass per byte
// a single output register decouples the sides; req stalls only while it holds
// a beat that rsp does not take
// reset clears parser state, the csr registers and the output valid flag
module tls_server_stream_parser_unit
   import tsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   tsp_req_if.sink     req_bus,
   tsp_rsp_if.source   rsp_bus,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [0:0]  csr_wdata
);

   tsp_cfg_type    cfg_ff;
   tsp_result_type result;
   tsp_result_type rsp_ff;
   logic           rsp_valid_ff;
   logic           accept;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept = req_bus.valid && req_bus.ready;

   tsp_core u_core (
      .clock          (clock),
      .reset          (reset),
      .step           (accept),
      .rx_byte        (req_bus.rx_byte),
      .new_connection (req_bus.new_connection),
      .cfg            (cfg_ff),
      .result         (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CAPTURE_CERT:  cfg_ff.capture_cert <= csr_wdata[0];
            CSR_CAPTURE_BLEED: cfg_ff.capture_heartbleed <= csr_wdata[0];
            CSR_BLEED_MODE:    cfg_ff.heartbleed_mode <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_bus.valid              = rsp_valid_ff;
   assign rsp_bus.cipher_valid       = rsp_ff.cipher_valid;
   assign rsp_bus.suite_id           = rsp_ff.suite_id;
   assign rsp_bus.heartbeat_ext_seen = rsp_ff.heartbeat_ext_seen;
   assign rsp_bus.heartbleed_seen    = rsp_ff.heartbleed_seen;
   assign rsp_bus.send_probe         = rsp_ff.send_probe;
   assign rsp_bus.capture_start      = rsp_ff.capture_start;
   assign rsp_bus.payload_valid      = rsp_ff.payload_valid;
   assign rsp_bus.payload_kind       = rsp_ff.payload_kind;
   assign rsp_bus.capture_end        = rsp_ff.capture_end;
   assign rsp_bus.scan_done          = rsp_ff.scan_done;
   assign rsp_bus.stream_dead        = rsp_ff.stream_dead;

   a_suite_only_when_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.cipher_valid |-> rsp_ff.suite_id == '0)
      else $error("cipher suite without cipher_valid");

   a_end_is_cert: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.capture_end |-> !rsp_ff.payload_kind)
      else $error("certificate end tagged as heartbeat");

   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted byte produced no result");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff)
      else $error("result valid right after reset");

endmodule

>>> dv/tsp_checker.sv
module tsp_checker
   import tsp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   tsp_req_if         req_bus,
   tsp_rsp_if         rsp_bus,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [0:0] csr_wdata,
   output int         fail_count,
   output int         pending,
   output int         n_results,
   output int         n_cipher,
   output int         n_payload
);
   timeunit 1ns;
   timeprecision 1ps;

   logic        cap_cert, cap_bleed, bleed_mode;
   logic [2:0]  rec_ph, in_ph, ch_ph;
   logic [15:0] rec_left, hl, suite, ek, el;
   logic [7:0]  rec_kind, msg, hmaj;
   logic [4:0]  h_ph;
   logic [23:0] in_left, ch_left, crt_left;
   tsp_result_type r;
   tsp_result_type expected_q[$];

   function automatic void clear_parsers();
      rec_ph = REC_TYPE; rec_left = '0; rec_kind = '0;
      in_ph = IN_TYPE; in_left = '0; msg = '0;
      h_ph = H_VMAJ; hl = '0; hmaj = '0; suite = '0; ek = '0; el = '0;
      ch_ph = C_LEN0; ch_left = '0; crt_left = '0;
   endfunction

   function automatic void hello_step(logic [7:0] b);
      bit again;
      again = 1;
      while (again) begin
         again = 0;
         case (h_ph)
            H_VMAJ: begin hmaj = b; h_ph = H_VMIN; end
            H_VMIN: h_ph = (hmaj > 3 || b > 4) ? H_DEAD : H_TIME0;
            H_TIME0, H_TIME1, H_TIME2: h_ph = h_ph + 5'd1;
            H_TIME3: begin hl = RANDOM_LEN; h_ph = H_RANDOM; end
            H_RANDOM: begin
               if (hl == 0) begin
                  h_ph = H_SESSLEN; again = 1;
               end else begin
                  hl--;
                  if (hl == 0) h_ph = H_SESSLEN;
               end
            end
            H_SESSLEN: begin hl = {8'd0, b}; h_ph = H_SESSID; end
            H_SESSID: begin
               if (hl == 0) begin
                  suite = '0; h_ph = H_CIPH0; again = 1;
               end else begin
                  hl--;
                  if (hl == 0) begin suite = '0; h_ph = H_CIPH0; end
               end
            end
            H_CIPH0: begin suite = {suite[7:0], b}; h_ph = H_CIPH1; end
            H_CIPH1: begin
               suite = {suite[7:0], b};
               r.cipher_valid = 1; r.suite_id = suite;
               h_ph = H_COMP;
            end
            H_COMP: h_ph = H_LEN0;
            H_LEN0: begin hl = {8'd0, b}; h_ph = H_LEN1; end
            H_LEN1: begin hl = {hl[7:0], b}; h_ph = H_TAG0; end
            H_TAG0: begin
               if (hl < 4) h_ph = H_DEAD;
               else begin ek = {b, 8'd0}; hl--; h_ph = H_TAG1; end
            end
            H_TAG1: begin ek = ek | {8'd0, b}; hl--; h_ph = H_ELEN0; end
            H_ELEN0: begin el = {b, 8'd0}; hl--; h_ph = H_ELEN1; end
            H_ELEN1: begin
               el = el | {8'd0, b}; hl--;
               h_ph = (ek == EXT_HEARTBEAT) ? H_HBDATA : H_DATA;
            end
            H_DATA, H_HBDATA: begin
               if (el == 0) begin
                  h_ph = H_TAG0; again = 1;
               end else if (hl == 0) begin
                  h_ph = H_DEAD;
               end else begin
                  hl--; el--;
                  if (h_ph == H_HBDATA && b != 0) r.heartbeat_ext_seen = 1;
                  h_ph = H_DATA;
               end
            end
            default: ;
         endcase
      end
   endfunction

   function automatic void finish_cert();
      if (cap_cert) r.capture_end = 1;
      ch_ph = C_CLEN0;
      if (ch_left == 0 && !bleed_mode) r.scan_done = 1;
   endfunction

   function automatic void chain_step(logic [7:0] b);
      bit again;
      again = 1;
      while (again) begin
         again = 0;
         case (ch_ph)
            C_LEN0: begin ch_left = {16'd0, b}; ch_ph = C_LEN1; end
            C_LEN1, C_LEN2: begin ch_left = {ch_left[15:0], b}; ch_ph = ch_ph + 3'd1; end
            C_CLEN0: begin
               if (ch_left < 3) ch_ph = C_DEAD;
               else begin crt_left = {16'd0, b}; ch_left--; ch_ph = C_CLEN1; end
            end
            C_CLEN1: begin crt_left = {crt_left[15:0], b}; ch_left--; ch_ph = C_CLEN2; end
            C_CLEN2: begin
               crt_left = {crt_left[15:0], b}; ch_left--;
               if (cap_cert) r.capture_start = 1;
               ch_ph = C_CERT;
            end
            C_CERT: begin
               if (crt_left == 0) begin
                  finish_cert(); again = 1;
               end else if (ch_left == 0) begin
                  ch_ph = C_DEAD;
               end else begin
                  if (cap_cert) begin r.payload_valid = 1; r.payload_kind = 0; end
                  ch_left--; crt_left--;
                  if (crt_left == 0) finish_cert();
               end
            end
            default: ;
         endcase
      end
   endfunction

   function automatic void handshake_step(logic [7:0] b);
      bit again;
      again = 1;
      while (again) begin
         again = 0;
         case (in_ph)
            IN_TYPE: begin
               if (b[7]) in_ph = IN_DEAD;
               else begin
                  msg = b; h_ph = H_VMAJ; ch_ph = C_LEN0; in_ph = IN_LEN0;
               end
            end
            IN_LEN0: begin in_left = {16'd0, b}; in_ph = IN_LEN1; end
            IN_LEN1: begin in_left = {in_left[15:0], b}; in_ph = IN_LEN2; end
            IN_LEN2: begin
               in_left = {in_left[15:0], b};
               if (msg == MSG_HELLO) r.send_probe = 1;
               in_ph = IN_BODY;
            end
            IN_BODY: begin
               if (in_left == 0) begin
                  in_ph = IN_TYPE; again = 1;
               end else begin
                  if (msg == MSG_HELLO) hello_step(b);
                  else if (msg == MSG_CERT) chain_step(b);
                  in_left--;
                  if (in_left == 0) in_ph = IN_TYPE;
               end
            end
            default: ;
         endcase
      end
   endfunction

   function automatic void heartbeat_step(logic [7:0] b);
      case (in_ph)
         IN_TYPE: begin
            if (b < 1 || b > 2) in_ph = IN_DEAD;
            else begin msg = b; in_ph = IN_LEN0; end
         end
         IN_LEN0: begin in_left = {16'd0, b}; in_ph = IN_LEN1; end
         IN_LEN1: begin
            in_left = {in_left[15:0], b};
            if (msg == HB_RESPONSE) begin
               if (in_left >= BLEED_MIN) r.heartbleed_seen = 1;
               if (cap_bleed) begin r.capture_start = 1; r.payload_kind = 1; end
            end
            in_ph = IN_BODY;
         end
         IN_BODY: begin
            if (in_left == 0) in_ph = IN_DEAD;
            else begin
               if (msg == HB_RESPONSE && cap_bleed) begin
                  r.payload_valid = 1; r.payload_kind = 1;
               end
               in_left--;
               if (in_left == 0) in_ph = IN_DEAD;
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void record_step(logic [7:0] b);
      bit again;
      again = 1;
      while (again) begin
         again = 0;
         case (rec_ph)
            REC_TYPE: begin
               if (b[7]) rec_ph = REC_DEAD;
               else begin
                  if (rec_kind != b) begin rec_kind = b; in_ph = IN_TYPE; end
                  rec_ph = REC_VMAJ;
               end
            end
            REC_VMAJ: rec_ph = (b != 3) ? REC_DEAD : REC_VMIN;
            REC_VMIN: rec_ph = REC_LEN0;
            REC_LEN0: begin rec_left = {b, 8'd0}; rec_ph = REC_LEN1; end
            REC_LEN1: begin rec_left = rec_left | {8'd0, b}; rec_ph = REC_BODY; end
            REC_BODY: begin
               if (rec_left == 0) begin
                  rec_ph = REC_TYPE; again = 1;
               end else begin
                  if (rec_kind == KIND_HANDSHAKE) handshake_step(b);
                  else if (rec_kind == KIND_HEARTBEAT) heartbeat_step(b);
                  rec_left--;
                  if (rec_left == 0) rec_ph = REC_TYPE;
               end
            end
            default: ;
         endcase
      end
   endfunction

   always @(negedge clock) begin
      tsp_result_type got;
      tsp_result_type want;
      if (reset) begin
         cap_cert = 0; cap_bleed = 0; bleed_mode = 0;
         clear_parsers();
         expected_q.delete();
         fail_count = 0; n_results = 0; n_cipher = 0; n_payload = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_CAPTURE_CERT:  cap_cert = csr_wdata[0];
               CSR_CAPTURE_BLEED: cap_bleed = csr_wdata[0];
               CSR_BLEED_MODE:    bleed_mode = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            if (req_bus.new_connection) clear_parsers();
            r = '0;
            record_step(req_bus.rx_byte);
            r.stream_dead = (rec_ph >= REC_DEAD);
            expected_q.push_back(r);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.cipher_valid       = rsp_bus.cipher_valid;
            got.suite_id           = rsp_bus.suite_id;
            got.heartbeat_ext_seen = rsp_bus.heartbeat_ext_seen;
            got.heartbleed_seen    = rsp_bus.heartbleed_seen;
            got.send_probe         = rsp_bus.send_probe;
            got.capture_start      = rsp_bus.capture_start;
            got.payload_valid      = rsp_bus.payload_valid;
            got.payload_kind       = rsp_bus.payload_kind;
            got.capture_end        = rsp_bus.capture_end;
            got.scan_done          = rsp_bus.scan_done;
            got.stream_dead        = rsp_bus.stream_dead;
            n_results++;
            if (got.cipher_valid) n_cipher++;
            if (got.payload_valid) n_payload++;
            if (expected_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result beat %p", $time, got);
            end else begin
               want = expected_q.pop_front();
               if (got !== want) begin
                  fail_count++;
                  $display("%0t: result mismatch expected %p actual %p", $time, want, got);
               end
            end
         end
      end
      pending = expected_q.size();
   end
endmodule

>>> dv/tls_server_stream_parser_unit_tb.sv
module tls_server_stream_parser_unit_tb;
   import tsp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic       clock;
   logic       reset;
   logic       csr_we;
   logic [1:0] csr_index;
   logic [0:0] csr_wdata;
   int         fail_count, pending, n_results, n_cipher, n_payload;
   int         snd_idle, rcv_stall, hold_asks, stall_cycles, n_items, n_conns;
   logic [8:0] tx_q[$];
   logic [7:0] msg_q[$];
   logic [7:0] body_q[$];

   tsp_req_if req_bus ();
   tsp_rsp_if rsp_bus ();

   tls_server_stream_parser_unit i_dut (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   tsp_checker i_checker (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending(pending), .n_results(n_results),
      .n_cipher(n_cipher), .n_payload(n_payload)
   );

   initial begin
      clock = 0; reset = 1; csr_we = 0; csr_index = '0; csr_wdata = '0;
      req_bus.valid = 0; req_bus.rx_byte = '0; req_bus.new_connection = 0;
      rsp_bus.ready = 0; snd_idle = 0; rcv_stall = 0; hold_asks = 0;
   end

   always #5 clock = ~clock;

   // receiver: random stalls plus a single long hold-off in the first phase
   always @(posedge clock) begin
      int seen, hold;
      if (reset) begin
         rsp_bus.ready <= 0;
      end else if (seen != hold_asks) begin
         seen = hold_asks; hold = 300;
         rsp_bus.ready <= 0;
      end else if (hold > 0) begin
         hold--;
         rsp_bus.ready <= 0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= rcv_stall);
      end
   end

   // watchdog on cycles without any beat
   always @(negedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         stall_cycles = 0;
      else if (++stall_cycles >= 5000) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic send_beat(input logic [7:0] b, input logic nc);
      bit took;
      while ($urandom_range(99) < snd_idle) begin
         req_bus.valid <= 0;
         @(posedge clock);
      end
      req_bus.valid <= 1; req_bus.rx_byte <= b; req_bus.new_connection <= nc;
      do begin
         @(negedge clock);
         took = req_bus.ready;
         @(posedge clock);
      end while (!took);
      n_items++;
   endtask

   task automatic drain();
      req_bus.valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic v);
      csr_we <= 1; csr_index <= idx; csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
      @(posedge clock);
   endtask

   function automatic void put_body24(input logic [7:0] kind);
      int n;
      n = body_q.size() + (($urandom_range(15) == 0) ? int'($urandom_range(0, 4)) - 2 : 0);
      if (n < 0) n = 0;
      msg_q.push_back(kind);
      msg_q.push_back(n[23:16]); msg_q.push_back(n[15:8]); msg_q.push_back(n[7:0]);
      foreach (body_q[i]) msg_q.push_back(body_q[i]);
      body_q.delete();
   endfunction

   function automatic void add_hello();
      int sl, ne, el, xl;
      logic [7:0] ext[$];
      body_q.push_back(($urandom_range(19) == 0) ? 8'($urandom_range(4, 255)) : 8'd3);
      body_q.push_back(($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4)));
      repeat (32) body_q.push_back(8'($urandom));
      sl = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 32);
      body_q.push_back(8'(sl));
      repeat (sl) body_q.push_back(8'($urandom));
      repeat (3) body_q.push_back(8'($urandom));
      ne = $urandom_range(0, 3);
      repeat (ne) begin
         if ($urandom_range(1)) begin ext.push_back(8'h00); ext.push_back(8'h0f); end
         else begin ext.push_back(8'($urandom)); ext.push_back(8'($urandom)); end
         el = $urandom_range(0, 4);
         ext.push_back(8'h00); ext.push_back(8'(el));
         repeat (el) ext.push_back(($urandom_range(2) == 0) ? 8'h00 : 8'($urandom));
      end
      xl = ext.size();
      if ($urandom_range(9) == 0) xl = $urandom_range(0, 5);
      body_q.push_back(8'(xl >> 8)); body_q.push_back(8'(xl));
      foreach (ext[i]) body_q.push_back(ext[i]);
      put_body24(MSG_HELLO);
   endfunction

   function automatic void add_chain();
      int nc, cl, total;
      logic [7:0] certs[$];
      nc = $urandom_range(0, 3);
      repeat (nc) begin
         cl = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 20);
         certs.push_back(8'(cl >> 16)); certs.push_back(8'(cl >> 8)); certs.push_back(8'(cl));
         if ($urandom_range(9) == 0) cl = cl - 1 + $urandom_range(0, 2);
         repeat (cl) certs.push_back(8'($urandom));
      end
      total = certs.size();
      if ($urandom_range(9) == 0) total = $urandom_range(0, total + 4);
      body_q.push_back(8'(total >> 16)); body_q.push_back(8'(total >> 8));
      body_q.push_back(8'(total));
      foreach (certs[i]) body_q.push_back(certs[i]);
      put_body24(MSG_CERT);
   endfunction

   function automatic void emit_records(input logic [7:0] kind);
      int idx, n;
      idx = 0;
      while (idx < msg_q.size()) begin
         n = (msg_q.size() - idx > 80) ? 80 : msg_q.size() - idx;
         n = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, n);
         tx_q.push_back({1'b0, kind}); tx_q.push_back(9'd3);
         tx_q.push_back(9'($urandom_range(0, 4)));
         tx_q.push_back({1'b0, 8'(n >> 8)}); tx_q.push_back({1'b0, 8'(n)});
         repeat (n) tx_q.push_back({1'b0, msg_q[idx++]});
      end
      msg_q.delete();
   endfunction

   function automatic void add_heartbeat();
      int hl;
      msg_q.push_back(($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 2)));
      hl = $urandom_range(0, 40);
      msg_q.push_back(8'(hl >> 8)); msg_q.push_back(8'(hl));
      repeat (hl + $urandom_range(0, 4)) msg_q.push_back(8'($urandom));
      emit_records(KIND_HEARTBEAT);
   endfunction

   // one connection: mostly a well-formed server flight, sometimes noise
   function automatic void build_connection();
      int first;
      first = tx_q.size();
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(1, 20))
            tx_q.push_back({1'($urandom_range(7) == 0), 8'($urandom)});
      end else begin
         if ($urandom_range(4) != 0) add_hello();
         if ($urandom_range(4) != 0) add_chain();
         if ($urandom_range(3) == 0) msg_q.push_back(8'($urandom_range(0, 20)));
         emit_records(KIND_HANDSHAKE);
         if ($urandom_range(1)) add_heartbeat();
         if ($urandom_range(4) == 0) begin add_chain(); emit_records(KIND_HANDSHAKE); end
         if (tx_q.size() > first && $urandom_range(9) == 0)
            tx_q[$urandom_range(first, tx_q.size() - 1)] ^= 9'(1 << $urandom_range(7));
      end
      if (tx_q.size() > first) tx_q[first][8] = 1;
      n_conns++;
   endfunction

   initial begin
      logic [8:0] directed[$];
      logic [2:0] cfg;
      int target;
      directed = '{9'h180, 9'h0ff, 9'h116, 9'h003, 9'h001, 9'h000, 9'h000,
                   9'h016, 9'h003, 9'h003, 9'h000, 9'h004, 9'h080, 9'h000,
                   9'h000, 9'h000, 9'h118, 9'h003, 9'h003, 9'h000, 9'h001,
                   9'h007};
      n_items = 0; n_conns = 0;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      write_reg(CSR_CAPTURE_CERT, 0);
      write_reg(CSR_CAPTURE_BLEED, 0);
      write_reg(CSR_BLEED_MODE, 0);
      foreach (directed[i]) send_beat(directed[i][7:0], directed[i][8]);
      drain();
      for (int p = 0; p < 8; p++) begin
         cfg = (p == 0) ? 3'b000 : (p == 1) ? 3'b111 : 3'($urandom);
         write_reg(CSR_CAPTURE_CERT, cfg[0]);
         write_reg(CSR_CAPTURE_BLEED, cfg[1]);
         write_reg(CSR_BLEED_MODE, cfg[2]);
         case (p % 4)
            0: begin snd_idle = 0; rcv_stall = 0; end
            1: begin snd_idle = 66; rcv_stall = 0; end
            2: begin snd_idle = 0; rcv_stall = 66; end
            default: begin snd_idle = 20; rcv_stall = 20; end
         endcase
         if (p == 0) hold_asks++;
         target = n_items + 170;
         while (n_items < target) begin
            build_connection();
            while (tx_q.size() != 0) begin
               logic [8:0] t;
               t = tx_q.pop_front();
               send_beat(t[7:0], t[8]);
            end
         end
         drain();
      end
      $display("sent %0d bytes over %0d connections in 8 register/idling phases",
               n_items, n_conns);
      $display("checked %0d results: %0d cipher suites, %0d capture payload bytes",
               n_results, n_cipher, n_payload);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule
